### sv/pbx_line_controller_core_assert.svh
// ----------------------------------------------------------------------------
// pbx line controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PBX_LINE_CONTROLLER_CORE_ASSERT_SVH
`define PBX_LINE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define PBX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbx line controller assertion failed");

// next-cycle implication
`define PBX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbx line controller assertion failed");

`endif

### sv/pbx_pkg.sv
// ----------------------------------------------------------------------------
// pbx_pkg
// Types and constants of the pbx line controller: beat structs, exchange
// modes, dial events, cadence patterns and the dtmf key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbx_pkg;

  // number of lines that can be rung by a star code
  localparam int unsigned LINE_COUNT = 5;

  // configuration register indexes
  typedef enum logic {
    CFG_SAMPLE_PERIOD  = 1'b0,
    CFG_CADENCE_PERIOD = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 10;

  // reset values of the configuration registers
  localparam logic [7:0] SAMPLE_PERIOD_RST  = 8'd5;
  localparam logic [9:0] CADENCE_PERIOD_RST = 10'd330;

  // exchange modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_READY = 3'd1,
    MODE_CALL  = 3'd2,
    MODE_RING  = 3'd3,
    MODE_BUSY  = 3'd4
  } mode_e;

  // dial events
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PUSH = 2'd1,
    EV_RING = 2'd2,
    EV_BUSY = 2'd3
  } dial_ev_e;

  // strobe history that marks a settled key press
  localparam logic [15:0] STROBE_MATCH = 16'h7FFF;

  // tone cadence patterns
  localparam logic [15:0] CAD_DIAL  = 16'h000D;
  localparam logic [15:0] CAD_READY = 16'h0034;
  localparam logic [15:0] CAD_BUSY  = 16'h02AA;
  localparam logic [15:0] CAD_RING  = 16'h000F;
  localparam logic [15:0] CAD_RBACK = 16'hF000;

  // key characters
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  typedef struct packed {
    logic [4:0] offhook_mask;
    logic       dtmf_valid;
    logic [3:0] dtmf_code;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] exchange_state;
    logic [4:0] ringing_lines;
    logic       tone_on;
    logic [1:0] dial_event;
  } out_beat_t;

  // dtmf decoder code to key character
  function automatic logic [7:0] key_char(input logic [3:0] code);
    logic [7:0] ch;
    unique case (code)
      4'd0:  ch = 8'h44;  // D
      4'd1:  ch = 8'h38;  // 8
      4'd2:  ch = 8'h34;  // 4
      4'd3:  ch = 8'h23;  // #
      4'd4:  ch = 8'h32;  // 2
      4'd5:  ch = 8'h30;  // 0
      4'd6:  ch = 8'h36;  // 6
      4'd7:  ch = 8'h42;  // B
      4'd8:  ch = 8'h31;  // 1
      4'd9:  ch = 8'h39;  // 9
      4'd10: ch = 8'h35;  // 5
      4'd11: ch = 8'h41;  // A
      4'd12: ch = 8'h33;  // 3
      4'd13: ch = 8'h2A;  // *
      4'd14: ch = 8'h37;  // 7
      default: ch = 8'h43;  // C
    endcase
    return ch;
  endfunction

endpackage

### sv/pbx_line_controller_core.sv
// ----------------------------------------------------------------------------
// pbx_line_controller_core
// Tick-driven controller of a small five-line telephone exchange.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat per
// millisecond tick with the off-hook mask and the dtmf strobe and code.
// Output channel (out_valid_o / out_ready_i / out_data_o): one beat per
// input beat with exchange mode, ringing lines, tone gate and dial event.
// Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): index 0 is the strobe
// sample period, index 1 the cadence period; write only while idle.
// The result of a beat is registered and shows on the output in the cycle
// after it is taken. Throughput: one beat per cycle; all tick work is one
// pass of logic from the input port into the state and result registers.
// A stalled receiver holds the result register; a new beat is still taken
// in the cycle the waiting result leaves, so ready only drops while a
// result waits and out_ready_i is low.
// Reset sets mode idle and periods to 5 and 330; the digit store is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbx_line_controller_core #(
  parameter int unsigned DIGIT_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pbx_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pbx_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pbx_pkg::out_beat_t            out_data_o
);

  localparam int unsigned IdxW = $clog2(DIGIT_SLOTS + 1);

  // configuration registers
  logic [7:0] sample_period_q;
  logic [9:0] cadence_period_q;

  // tick state
  pbx_pkg::mode_e   mode_q, mode_d;
  logic [15:0]      cad_q, cad_d, cad_fsm;
  logic [4:0]       ring_q, ring_d, ring_dig, ring_fsm;
  logic [2:0]       prev_cnt_q;
  logic [15:0]      hist_q, hist_d;
  logic [IdxW-1:0]  idx_q, idx_d, idx_clr;
  logic [7:0]       store_q [2];
  logic [7:0]       st0_d, st1_d;
  logic [7:0]       stimer_q, stimer_d, stimer_nx;
  logic [9:0]       ctimer_q, ctimer_d, ctimer_nx;
  logic             tone_q, tone_d;

  // result register
  logic               out_valid_q;
  pbx_pkg::out_beat_t out_q, out_d;

  logic accept;
  logic [2:0] cnt;
  logic hangup, clr_dig, s_fire, c_fire, push, star_hit, line_ok;
  logic [7:0] diff;
  logic [4:0] line_bit;
  pbx_pkg::dial_ev_e ev;
  logic ring_ev;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q  <= pbx_pkg::SAMPLE_PERIOD_RST;
      cadence_period_q <= pbx_pkg::CADENCE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (pbx_pkg::cfg_idx_e'(cfg_idx_i))
        pbx_pkg::CFG_SAMPLE_PERIOD:  sample_period_q  <= cfg_wdata_i[7:0];
        pbx_pkg::CFG_CADENCE_PERIOD: cadence_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // lifted handset count and hang-up
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 5; i++) begin
      cnt = cnt + 3'(in_data_i.offhook_mask[i]);
    end
  end
  assign hangup  = cnt < prev_cnt_q;
  assign clr_dig = (cnt == 3'd0) || hangup;

  // timers: fire when the new count reaches the period or wraps
  assign stimer_nx = stimer_q + 8'd1;
  assign s_fire    = (stimer_nx >= sample_period_q) || (stimer_nx == 8'd0);
  assign stimer_d  = s_fire ? 8'd0 : stimer_nx;
  assign ctimer_nx = ctimer_q + 10'd1;
  assign c_fire    = (ctimer_nx >= cadence_period_q) || (ctimer_nx == 10'd0);
  assign ctimer_d  = c_fire ? 10'd0 : ctimer_nx;

  // strobe sampling, digit store and star code
  always_comb begin
    idx_clr  = clr_dig ? '0 : idx_q;
    idx_d    = idx_clr;
    hist_d   = hist_q;
    st0_d    = store_q[0];
    st1_d    = store_q[1];
    push     = 1'b0;
    ring_dig = ring_q;
    ev       = pbx_pkg::EV_NONE;
    diff     = st1_d - pbx_pkg::CHAR_ONE;
    line_ok  = 1'b0;
    line_bit = '0;
    star_hit = 1'b0;
    if (s_fire) begin
      hist_d = {hist_q[14:0], in_data_i.dtmf_valid};
      if (hist_d == pbx_pkg::STROBE_MATCH) begin
        push = 1'b1;
        ev   = pbx_pkg::EV_PUSH;
        if (idx_clr == IdxW'(0)) st0_d = pbx_pkg::key_char(in_data_i.dtmf_code);
        if (idx_clr == IdxW'(1)) st1_d = pbx_pkg::key_char(in_data_i.dtmf_code);
        if (idx_clr < IdxW'(DIGIT_SLOTS)) idx_d = idx_clr + IdxW'(1);
      end
      diff     = st1_d - pbx_pkg::CHAR_ONE;
      line_ok  = (st1_d >= pbx_pkg::CHAR_ONE) && (diff < 8'(pbx_pkg::LINE_COUNT))
                 && (diff < 8'd5);
      line_bit = 5'd1 << diff[2:0];
      star_hit = (idx_d == IdxW'(2)) && (st0_d == pbx_pkg::CHAR_STAR);
      if (star_hit) begin
        // the star code result replaces the digit push event
        push  = 1'b0;
        idx_d = '0;
        if (line_ok && ((in_data_i.offhook_mask & line_bit) == 5'd0)) begin
          ring_dig = ring_q | line_bit;
          ev       = pbx_pkg::EV_RING;
        end else begin
          ev = pbx_pkg::EV_BUSY;
        end
      end
    end
  end

  // mode next state
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      pbx_pkg::MODE_READY: begin
        if (cnt > 3'd1 || push)  mode_d = pbx_pkg::MODE_CALL;
        else if (cnt == 3'd0)    mode_d = pbx_pkg::MODE_IDLE;
      end
      pbx_pkg::MODE_CALL: begin
        if (ev == pbx_pkg::EV_BUSY)      mode_d = pbx_pkg::MODE_BUSY;
        else if (ev == pbx_pkg::EV_RING) mode_d = pbx_pkg::MODE_RING;
        else if (cnt == 3'd0)            mode_d = pbx_pkg::MODE_IDLE;
      end
      pbx_pkg::MODE_RING: begin
        if ((in_data_i.offhook_mask & ring_dig) != 5'd0) mode_d = pbx_pkg::MODE_CALL;
        else if (push || hangup)                        mode_d = pbx_pkg::MODE_CALL;
        else if (cnt == 3'd0)                           mode_d = pbx_pkg::MODE_IDLE;
      end
      pbx_pkg::MODE_BUSY: begin
        if (cad_q == 16'd0)    mode_d = pbx_pkg::MODE_CALL;
        else if (cnt == 3'd0)  mode_d = pbx_pkg::MODE_IDLE;
      end
      default: begin
        mode_d = (cnt != 3'd0) ? pbx_pkg::MODE_READY : pbx_pkg::MODE_IDLE;
      end
    endcase
  end

  // mode actions: cadence loads and ring mask clears
  always_comb begin
    cad_fsm  = cad_q;
    ring_fsm = ring_dig;
    unique case (mode_q)
      pbx_pkg::MODE_READY: begin
        if (!(cnt > 3'd1 || push) && cnt != 3'd0 && cad_q == 16'd0) begin
          cad_fsm = pbx_pkg::CAD_READY;
        end
      end
      pbx_pkg::MODE_CALL: begin
        if (ev == pbx_pkg::EV_BUSY) begin
          cad_fsm = pbx_pkg::CAD_BUSY;
        end else if (ev == pbx_pkg::EV_RING) begin
          cad_fsm = pbx_pkg::CAD_RING;
        end else if (cnt != 3'd0) begin
          cad_fsm  = '0;
          ring_fsm = '0;
        end
      end
      pbx_pkg::MODE_RING: begin
        if ((in_data_i.offhook_mask & ring_dig) == 5'd0 && !push && !hangup
            && cnt != 3'd0 && cad_q == 16'd0) begin
          cad_fsm = pbx_pkg::CAD_RBACK;
        end
      end
      pbx_pkg::MODE_BUSY: ;
      default: begin
        if (cnt != 3'd0) begin
          cad_fsm = pbx_pkg::CAD_DIAL;
        end else begin
          cad_fsm  = '0;
          ring_fsm = '0;
        end
      end
    endcase
  end

  // cadence shift and result beat
  always_comb begin
    cad_d  = cad_fsm;
    tone_d = tone_q;
    ring_d = ring_fsm;
    if (c_fire) begin
      tone_d = cad_fsm[0];
      cad_d  = {1'b0, cad_fsm[15:1]};
    end
    out_d.exchange_state = mode_d;
    out_d.ringing_lines  = ring_d;
    out_d.tone_on        = tone_d;
    out_d.dial_event     = ev;
  end

  // tick state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= pbx_pkg::MODE_IDLE;
      cad_q      <= '0;
      ring_q     <= '0;
      prev_cnt_q <= '0;
      hist_q     <= '0;
      idx_q      <= '0;
      stimer_q   <= '0;
      ctimer_q   <= '0;
      tone_q     <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      cad_q      <= cad_d;
      ring_q     <= ring_d;
      prev_cnt_q <= cnt;
      hist_q     <= hist_d;
      idx_q      <= idx_d;
      stimer_q   <= stimer_d;
      ctimer_q   <= ctimer_d;
      tone_q     <= tone_d;
    end
  end

  // digit store, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[0] <= st0_d;
      store_q[1] <= st1_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  // ring event on the result beat
  assign ring_ev = out_data_o.dial_event == pbx_pkg::EV_RING;

`include "pbx_line_controller_core_assert.svh"

  `PBX_ASSERT_IMP(a_no_overwrite, in_valid_i && in_ready_o, !(out_valid_o && !out_ready_i))
  `PBX_ASSERT_NXT(a_result_follows, in_valid_i && in_ready_o, out_valid_o)
  `PBX_ASSERT_IMP(a_idx_bound, 1'b1, idx_q <= IdxW'(DIGIT_SLOTS))
  `PBX_ASSERT_IMP(a_ring_has_line, out_valid_o && ring_ev, out_data_o.ringing_lines != 5'd0)

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pbx_line_controller_core. Tick beats come from a
// queue that the stimulus process fills: field extremes first, then random
// dial sequences (star codes, long digit runs, short strobes, hang-ups and
// noise). A cycle-free exchange predictor computes the result of every
// accepted beat, and the monitor compares each result beat field by field.
// The run walks through several strobe sample and cadence periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DigitSlots = 8;
  // total number of tick beats queued over the run
  localparam int TotalTicks = 1550;
  // dtmf code to key character, code 0 in the top byte
  localparam logic [127:0] KEY_ROM = "D84#206B195A3*7C";

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic                         cfg_idx_i   = pbx_pkg::CFG_SAMPLE_PERIOD;
  logic [pbx_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  pbx_pkg::in_beat_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  pbx_pkg::out_beat_t           out_data_o;

  pbx_line_controller_core #(
    .DIGIT_SLOTS(DigitSlots)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // predictor copy of the configuration and state
  logic [7:0]     sample_period  = pbx_pkg::SAMPLE_PERIOD_RST;
  logic [9:0]     cadence_period = pbx_pkg::CADENCE_PERIOD_RST;
  pbx_pkg::mode_e mode_q         = pbx_pkg::MODE_IDLE;
  logic [15:0]    cadence_q      = '0;
  logic [15:0]    strobe_hist    = '0;
  logic [4:0]     ring_q         = '0;
  logic [2:0]     lifted_prev    = '0;
  logic [3:0]     digit_cnt      = '0;
  logic [7:0]     digit_buf [2];
  logic [7:0]     sample_cnt     = '0;
  logic [9:0]     cadence_cnt    = '0;
  logic           tone_q         = 1'b0;

  pbx_pkg::in_beat_t  tick_q [$];
  pbx_pkg::out_beat_t status_q [$];
  int                 ticks_built = 0;
  int                 beats_taken = 0;
  int                 mismatches  = 0;

  function automatic logic [7:0] key_of(logic [3:0] code);
    return KEY_ROM[8*(15-code) +: 8];
  endfunction

  function automatic logic [3:0] code_for(logic [7:0] ch);
    logic [3:0] c;
    int k;
    c = '0;
    for (k = 0; k < 16; k++) if (key_of(4'(k)) == ch) c = 4'(k);
    return c;
  endfunction

  // one millisecond tick of the exchange
  function automatic pbx_pkg::out_beat_t exchange_tick(pbx_pkg::in_beat_t b);
    logic [2:0]         n_up;
    logic               hang;
    logic               sample_hit;
    logic [7:0]         s_next;
    logic [9:0]         c_next;
    pbx_pkg::dial_ev_e  ev;
    int                 ln;
    int                 i;
    pbx_pkg::out_beat_t r;
    n_up = '0;
    for (i = 0; i < 5; i++) n_up = n_up + {2'b00, b.offhook_mask[i]};
    hang = n_up < lifted_prev;
    lifted_prev = n_up;
    ev = pbx_pkg::EV_NONE;

    // digit collection, cleared on hang-up or all lines down
    if (n_up == 3'd0 || hang) digit_cnt = '0;
    s_next = sample_cnt + 8'd1;
    sample_hit = (s_next >= sample_period) || (s_next == 8'd0);
    sample_cnt = sample_hit ? 8'd0 : s_next;
    if (sample_hit) begin
      strobe_hist = {strobe_hist[14:0], b.dtmf_valid};
      if (strobe_hist == pbx_pkg::STROBE_MATCH) begin
        if (digit_cnt < 4'd2) digit_buf[digit_cnt[0]] = key_of(b.dtmf_code);
        if (digit_cnt < DigitSlots) digit_cnt++;
        ev = pbx_pkg::EV_PUSH;
      end
      // star code: ring the named line or report busy
      if (digit_cnt == 4'd2 && digit_buf[0] == pbx_pkg::CHAR_STAR) begin
        ln = int'(digit_buf[1]) - int'(pbx_pkg::CHAR_ONE);
        digit_cnt = '0;
        if (ln >= 0 && ln < int'(pbx_pkg::LINE_COUNT) && ln < 5) begin
          if (b.offhook_mask[ln]) begin
            ev = pbx_pkg::EV_BUSY;
          end else begin
            ring_q = ring_q | (5'd1 << ln);
            ev = pbx_pkg::EV_RING;
          end
        end else begin
          ev = pbx_pkg::EV_BUSY;
        end
      end
    end

    // exchange mode
    case (mode_q)
      pbx_pkg::MODE_READY: begin
        if (n_up > 3'd1 || ev == pbx_pkg::EV_PUSH) mode_q = pbx_pkg::MODE_CALL;
        else if (n_up == 3'd0) mode_q = pbx_pkg::MODE_IDLE;
        else if (cadence_q == '0) cadence_q = pbx_pkg::CAD_READY;
      end
      pbx_pkg::MODE_CALL: begin
        if (ev == pbx_pkg::EV_BUSY) begin
          mode_q = pbx_pkg::MODE_BUSY;
          cadence_q = pbx_pkg::CAD_BUSY;
        end else if (ev == pbx_pkg::EV_RING) begin
          mode_q = pbx_pkg::MODE_RING;
          cadence_q = pbx_pkg::CAD_RING;
        end else if (n_up == 3'd0) begin
          mode_q = pbx_pkg::MODE_IDLE;
        end else begin
          cadence_q = '0;
          ring_q = '0;
        end
      end
      pbx_pkg::MODE_RING: begin
        if ((b.offhook_mask & ring_q) != '0) mode_q = pbx_pkg::MODE_CALL;
        else if (ev == pbx_pkg::EV_PUSH || hang) mode_q = pbx_pkg::MODE_CALL;
        else if (n_up == 3'd0) mode_q = pbx_pkg::MODE_IDLE;
        else if (cadence_q == '0) cadence_q = pbx_pkg::CAD_RBACK;
      end
      pbx_pkg::MODE_BUSY: begin
        if (cadence_q == '0) mode_q = pbx_pkg::MODE_CALL;
        else if (n_up == 3'd0) mode_q = pbx_pkg::MODE_IDLE;
      end
      default: begin
        if (n_up > 3'd0) begin
          mode_q = pbx_pkg::MODE_READY;
          cadence_q = pbx_pkg::CAD_DIAL;
        end else begin
          mode_q = pbx_pkg::MODE_IDLE;
          cadence_q = '0;
          ring_q = '0;
        end
      end
    endcase

    // tone cadence shift
    c_next = cadence_cnt + 10'd1;
    if (c_next >= cadence_period || c_next == 10'd0) begin
      cadence_cnt = '0;
      tone_q = cadence_q[0];
      cadence_q = cadence_q >> 1;
    end else begin
      cadence_cnt = c_next;
    end

    r.exchange_state = mode_q;
    r.ringing_lines  = ring_q;
    r.tone_on        = tone_q;
    r.dial_event     = ev;
    return r;
  endfunction

  // idle rates: sender light first, then receiver light, then none
  function automatic int send_gap_pct();
    if (beats_taken < 520) return 23;
    if (beats_taken < 1040) return 69;
    return 0;
  endfunction

  function automatic int recv_gap_pct();
    if (beats_taken < 520) return 69;
    if (beats_taken < 1040) return 23;
    return 0;
  endfunction

  task automatic add_tick(logic [4:0] mask, logic strobe, logic [3:0] code);
    pbx_pkg::in_beat_t b;
    if (ticks_built >= TotalTicks) return;
    b.offhook_mask = mask;
    b.dtmf_valid   = strobe;
    b.dtmf_code    = code;
    tick_q.push_back(b);
    ticks_built++;
  endtask

  // key press: a quiet sample, then a run of strobe samples holding the code
  task automatic add_key(logic [4:0] mask, logic [3:0] code, int per, int ones);
    repeat (per) add_tick(mask, 1'b0, 4'($urandom_range(0, 15)));
    repeat (ones * per) add_tick(mask, 1'b1, code);
  endtask

  // one random dial sequence with a random tail of handset changes
  task automatic add_call(int per);
    logic [4:0] mask;
    logic [3:0] code;
    int         kind;
    int         pick;
    mask = 5'($urandom_range(1, 31));
    repeat ($urandom_range(1, 4)) add_tick(mask, 1'b0, 4'($urandom_range(0, 15)));
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // star code, mostly naming a real line
      add_key(mask, code_for(pbx_pkg::CHAR_STAR), per, 15);
      if ($urandom_range(0, 9) < 7)
        code = code_for(pbx_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
      else code = 4'($urandom_range(0, 15));
      add_key(mask, code, per, 15);
    end else if (kind == 6) begin
      // long digit run, which can fill and saturate the buffer
      repeat ($urandom_range(3, 10)) add_key(mask, 4'($urandom_range(0, 15)), per, 15);
    end else if (kind == 7) begin
      // strobe too short to count as a key
      add_key(mask, code_for(pbx_pkg::CHAR_STAR), per, $urandom_range(4, 14));
      add_key(mask, 4'($urandom_range(0, 15)), per, 15);
    end else if (kind == 8) begin
      // possible hang-up between the two digits
      add_key(mask, code_for(pbx_pkg::CHAR_STAR), per, 15);
      mask = mask & 5'($urandom_range(0, 31));
      add_key(mask, code_for(pbx_pkg::CHAR_ONE + 8'($urandom_range(0, 4))), per, 15);
    end else begin
      repeat ($urandom_range(5, 30))
        add_tick(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
    end
    repeat ($urandom_range(2, 24)) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) mask = mask;
      else if (pick < 7) mask = mask | 5'($urandom_range(0, 31));
      else if (pick < 9) mask = 5'($urandom_range(0, 31));
      else mask = '0;
      add_tick(mask, 1'($urandom_range(0, 3) == 0), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic write_cfg(pbx_pkg::cfg_idx_e idx, logic [pbx_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == pbx_pkg::CFG_SAMPLE_PERIOD) sample_period = val[7:0];
    else cadence_period = val;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic log_mismatch(string what, pbx_pkg::out_beat_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: exp state %0d ring %b tone %b ev %0d, ",
                "got state %0d ring %b tone %b ev %0d"},
               $realtime, what, want.exchange_state, want.ringing_lines, want.tone_on,
               want.dial_event, out_data_o.exchange_state, out_data_o.ringing_lines,
               out_data_o.tone_on, out_data_o.dial_event);
  endtask

  // input driver: predicts each accepted beat, then offers the next one
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      status_q.push_back(exchange_tick(in_data_i));
      beats_taken++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
        in_valid_i <= 1'b1;
        in_data_i  <= tick_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    pbx_pkg::out_beat_t want;
    if (out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        want = '0;
        log_mismatch("unexpected result beat", want);
      end else begin
        want = status_q.pop_front();
        if (want.exchange_state != out_data_o.exchange_state ||
            want.ringing_lines != out_data_o.ringing_lines ||
            want.tone_on != out_data_o.tone_on ||
            want.dial_event != out_data_o.dial_event)
          log_mismatch("result mismatch", want);
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_gap_pct());
  end

  // stimulus phases
  initial begin : stimulus
    int samp_tab [5];
    int cad_tab [5];
    int quota [5];
    int p;
    samp_tab = '{5, 1, 255, 2, 3};
    cad_tab  = '{330, 1, 1023, 6, 2};
    quota    = '{260, 760, 40, 1180, TotalTicks};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, hang-ups and idle returns
    add_tick(5'h00, 1'b0, 4'h0);
    add_tick(5'h1F, 1'b1, 4'hF);
    add_tick(5'h1F, 1'b0, 4'hF);
    add_tick(5'h01, 1'b1, 4'h0);
    add_tick(5'h10, 1'b0, 4'h8);
    add_tick(5'h00, 1'b1, 4'hD);
    add_tick(5'h15, 1'b1, 4'hA);
    add_tick(5'h0A, 1'b0, 4'h5);
    add_tick(5'h1F, 1'b1, 4'h3);
    add_tick(5'h00, 1'b0, 4'h0);

    for (p = 0; p < 5; p++) begin
      if (p > 0) begin
        write_cfg(pbx_pkg::CFG_SAMPLE_PERIOD, pbx_pkg::CfgDataW'(samp_tab[p]));
        write_cfg(pbx_pkg::CFG_CADENCE_PERIOD, pbx_pkg::CfgDataW'(cad_tab[p]));
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      if (p == 2) begin
        repeat (quota[p])
          add_tick(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
      end else begin
        while (ticks_built < quota[p]) add_call(samp_tab[p]);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("pbx_line_controller_core test passed");
    end else begin
      $display("pbx_line_controller_core test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("pbx_line_controller_core test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/pbx_pkg.sv
sv/pbx_line_controller_core.sv
tb/sv/tb_top.sv
